[sv/qrt_pkg.sv]
// ----------------------------------------------------------------------------
// qrt_pkg
// Shared types and constants for the quorum reply tally block: command and
// reply codes, register indexes, completion paths and the tally handshake.
// ----------------------------------------------------------------------------
package qrt_pkg;

    // Command codes of an input word
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    // Reply kinds
    localparam logic [1:0] RK_READ_ACK  = 2'd0;
    localparam logic [1:0] RK_WRITE_ACK = 2'd1;
    localparam logic [1:0] RK_RELAY     = 2'd2;

    // Client roles
    localparam logic ROLE_WRITER = 1'b0;
    localparam logic ROLE_READER = 1'b1;

    // Request kinds
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Completion paths
    localparam logic [1:0] PATH_WRITE = 2'd0;
    localparam logic [1:0] PATH_FAST  = 2'd1;
    localparam logic [1:0] PATH_SLOW  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROLE        = 2'd0;
    localparam logic [1:0] CFG_NUM_SERVERS = 2'd1;
    localparam logic [1:0] CFG_MAX_FAIL    = 2'd2;
    localparam logic [1:0] CFG_MAX_OPS     = 2'd3;

    // Fixed numbers
    localparam logic [31:0] MIN_SEED     = 32'd10000000;
    localparam logic [31:0] VALUE_OFFSET = 32'd900;
    localparam logic [6:0]  SAT7         = 7'd127;

    // Request from the sequencer to the tally walker
    typedef struct packed {
        logic        start;
        logic        clear;
        logic [31:0] ts;
        logic [31:0] value;
        logic [6:0]  majority;
    } qrt_tally_req_t;

    // Outcome of one relay lookup
    typedef struct packed {
        logic        done;
        logic        complete;
        logic        overflow;
        logic [31:0] stamp;
        logic [31:0] data;
    } qrt_tally_rsp_t;

endpackage

[sv/qrt_tally.sv]
// ----------------------------------------------------------------------------
// qrt_tally
// Relay tally table. Walks the used entries one at a time with a single
// timestamp comparator; bumps the vote count of a match or appends a new
// entry, and flags overflow when the table is full.
// ----------------------------------------------------------------------------
module qrt_tally #(
    parameter int TALLY_DEPTH = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  qrt_pkg::qrt_tally_req_t req,
    output qrt_pkg::qrt_tally_rsp_t rsp
);
    import qrt_pkg::*;

    localparam int IDX_W = (TALLY_DEPTH > 1) ? $clog2(TALLY_DEPTH) : 1;
    localparam int CNT_W = $clog2(TALLY_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TALLY_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_CMP    = 2'd2;
    localparam logic [1:0] ST_APPEND = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [31:0]      key_ts_reg, key_ts_next;
    logic [31:0]      key_val_reg, key_val_next;
    logic [6:0]       maj_reg, maj_next;

    logic [31:0] stamp_mem [TALLY_DEPTH];
    logic [31:0] data_mem  [TALLY_DEPTH];
    logic [6:0]  votes_mem [TALLY_DEPTH];

    logic [31:0] rd_stamp_reg;
    logic [31:0] rd_data_reg;
    logic [6:0]  rd_votes_reg;

    logic             wr_all;
    logic             wr_votes;
    logic [IDX_W-1:0] wr_addr;
    logic [6:0]       votes_inc;
    logic [CNT_W-1:0] idx_inc;
    logic             hit;

    assign votes_inc = (rd_votes_reg == SAT7) ? SAT7 : rd_votes_reg + 7'd1;
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign hit       = (rd_stamp_reg == key_ts_reg);

    // Walk the table
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        used_next    = used_reg;
        key_ts_next  = key_ts_reg;
        key_val_next = key_val_reg;
        maj_next     = maj_reg;
        wr_all       = 1'b0;
        wr_votes     = 1'b0;
        wr_addr      = idx_reg[IDX_W-1:0];
        rsp          = '0;

        if (req.clear)
        begin
            used_next = '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    key_ts_next  = req.ts;
                    key_val_next = req.value;
                    maj_next     = req.majority;
                    idx_next     = '0;
                    state_next   = (used_reg == '0) ? ST_APPEND : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (hit)
                begin
                    wr_votes     = 1'b1;
                    rsp.done     = 1'b1;
                    rsp.complete = (votes_inc >= maj_reg);
                    rsp.stamp    = rd_stamp_reg;
                    rsp.data     = rd_data_reg;
                    state_next   = ST_IDLE;
                end
                else if (idx_inc == used_reg)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_READ;
                end
            end
            ST_APPEND:
            begin
                rsp.done = 1'b1;
                if (used_reg < DEPTH_CNT)
                begin
                    wr_all    = 1'b1;
                    wr_addr   = used_reg[IDX_W-1:0];
                    used_next = used_reg + CNT_W'(1);
                end
                else
                begin
                    rsp.overflow = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            used_reg  <= used_next;
        end
    end

    // Hold the search key
    always_ff @(posedge clk)
    begin
        key_ts_reg  <= key_ts_next;
        key_val_reg <= key_val_next;
        maj_reg     <= maj_next;
    end

    // Table storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr_all)
        begin
            stamp_mem[wr_addr] <= key_ts_reg;
            data_mem[wr_addr]  <= key_val_reg;
            votes_mem[wr_addr] <= 7'd1;
        end
        else if (wr_votes)
        begin
            votes_mem[wr_addr] <= votes_inc;
        end
        rd_stamp_reg <= stamp_mem[idx_reg[IDX_W-1:0]];
        rd_data_reg  <= data_mem[idx_reg[IDX_W-1:0]];
        rd_votes_reg <= votes_mem[idx_reg[IDX_W-1:0]];
    end

endmodule

[sv/quorum_reply_tally.sv]
// ----------------------------------------------------------------------------
// quorum_reply_tally
// Client side of a quorum-replicated register: issues reads and writes and
// tallies server replies until a quorum or a majority completes the operation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per start command or
//   server reply. Every accepted word yields exactly one output word on the
//   out_valid/out_ready channel, in order.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   the user must see that it is written while the block is idle; the block does not enforce this.
// Sequence:
//   Start words, acks and ignored replies pass through the EXEC and EMIT
//   states before in_ready returns. A relay walks the tally table one used
//   entry at a time through one comparator, with a read and a compare state
//   per entry. The block takes one word at a time.
// Stall:
//   A finished word sits in the output register; the next input word is
//   taken while it waits, and its result is held until the register frees.
// Reset:
//   Clears busy, counters, the tally fill count and the output valid flag and
//   restores the default register settings. No clearing pass is needed.
// ----------------------------------------------------------------------------
module quorum_reply_tally #(
    parameter int TALLY_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [1:0]  reply_kind,
    input  logic [31:0] reply_ts,
    input  logic [31:0] reply_value,
    input  logic [31:0] reply_op,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output logic        request_issued,
    output logic        request_kind,
    output logic [31:0] request_ts,
    output logic [31:0] request_value,
    output logic [31:0] request_op,
    output logic        complete,
    output logic [1:0]  complete_path,
    output logic [31:0] result_ts,
    output logic [31:0] result_value,
    output logic        tally_overflow,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import qrt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    // configuration registers
    logic        role_reg;
    logic [6:0]  num_servers_reg;
    logic [5:0]  max_failures_reg;
    logic [31:0] max_ops_reg;

    // client state
    logic [31:0] op_counter_reg, op_counter_next;
    logic [31:0] write_stamp_reg, write_stamp_next;
    logic [31:0] write_data_reg, write_data_next;
    logic        busy_reg, busy_next;
    logic        finished_reg, finished_next;
    logic [6:0]  reply_count_reg, reply_count_next;
    logic [31:0] min_stamp_reg, min_stamp_next;
    logic [31:0] min_data_reg, min_data_next;

    // captured input word
    logic        cmd_reg;
    logic [1:0]  kind_reg;
    logic [31:0] ts_reg;
    logic [31:0] value_reg;
    logic [31:0] op_reg;

    // pending result word
    logic        p_issued_reg, p_issued_next;
    logic        p_kind_reg, p_kind_next;
    logic [31:0] p_req_ts_reg, p_req_ts_next;
    logic [31:0] p_req_val_reg, p_req_val_next;
    logic [31:0] p_req_op_reg, p_req_op_next;
    logic        p_done_reg, p_done_next;
    logic [1:0]  p_path_reg, p_path_next;
    logic [31:0] p_res_ts_reg, p_res_ts_next;
    logic [31:0] p_res_val_reg, p_res_val_next;
    logic        p_ovf_reg, p_ovf_next;

    logic out_valid_reg;
    logic out_load;

    qrt_tally_req_t tally_req;
    qrt_tally_rsp_t tally_rsp;

    logic        in_accept;
    logic        fresh;
    logic [6:0]  rc_inc;
    logic [6:0]  quorum;
    logic        reached;
    logic        ops_left;
    logic [31:0] op_inc;
    logic        ts_lower;
    logic [31:0] min_ts_new;
    logic [31:0] min_data_new;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Reply qualification and quorum arithmetic
    always_comb
    begin
        fresh = 1'b0;
        if (busy_reg)
        begin
            if (kind_reg == RK_READ_ACK || kind_reg == RK_RELAY)
            begin
                fresh = (op_reg == op_counter_reg);
            end
            else if (kind_reg == RK_WRITE_ACK)
            begin
                fresh = (ts_reg == write_stamp_reg);
            end
        end
    end

    assign rc_inc   = (reply_count_reg == SAT7) ? SAT7 : reply_count_reg + 7'd1;
    assign quorum   = ({1'b0, max_failures_reg} >= num_servers_reg) ? 7'd0
                    : num_servers_reg - {1'b0, max_failures_reg};
    assign reached  = (rc_inc >= quorum);
    assign ops_left = (op_counter_reg < max_ops_reg);
    assign op_inc   = op_counter_reg + 32'd1;
    assign ts_lower = (ts_reg < min_stamp_reg);
    assign min_ts_new   = ts_lower ? ts_reg : min_stamp_reg;
    assign min_data_new = ts_lower ? value_reg : min_data_reg;

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        op_counter_next  = op_counter_reg;
        write_stamp_next = write_stamp_reg;
        write_data_next  = write_data_reg;
        busy_next        = busy_reg;
        finished_next    = finished_reg;
        reply_count_next = reply_count_reg;
        min_stamp_next   = min_stamp_reg;
        min_data_next    = min_data_reg;
        p_issued_next    = p_issued_reg;
        p_kind_next      = p_kind_reg;
        p_req_ts_next    = p_req_ts_reg;
        p_req_val_next   = p_req_val_reg;
        p_req_op_next    = p_req_op_reg;
        p_done_next      = p_done_reg;
        p_path_next      = p_path_reg;
        p_res_ts_next    = p_res_ts_reg;
        p_res_val_next   = p_res_val_reg;
        p_ovf_next       = p_ovf_reg;
        tally_req          = '0;
        tally_req.ts       = ts_reg;
        tally_req.value    = value_reg;
        tally_req.majority = {1'b0, num_servers_reg[6:1]} + 7'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                p_issued_next  = 1'b0;
                p_kind_next    = REQ_WRITE;
                p_req_ts_next  = '0;
                p_req_val_next = '0;
                p_req_op_next  = '0;
                p_done_next    = 1'b0;
                p_path_next    = PATH_WRITE;
                p_res_ts_next  = '0;
                p_res_val_next = '0;
                p_ovf_next     = 1'b0;
                state_next     = ST_EMIT;
                if (cmd_reg == CMD_START)
                begin
                    if (role_reg == ROLE_WRITER)
                    begin
                        if (ops_left)
                        begin
                            op_counter_next  = op_inc;
                            write_stamp_next = write_stamp_reg + 32'd1;
                            write_data_next  = op_inc + VALUE_OFFSET;
                            busy_next        = 1'b1;
                            reply_count_next = '0;
                            p_issued_next    = 1'b1;
                            p_kind_next      = REQ_WRITE;
                            p_req_ts_next    = write_stamp_reg + 32'd1;
                            p_req_val_next   = op_inc + VALUE_OFFSET;
                            p_req_op_next    = op_inc;
                        end
                        else if (op_counter_reg != '1)
                        begin
                            op_counter_next = op_inc;
                        end
                    end
                    else if (ops_left)
                    begin
                        op_counter_next  = op_inc;
                        busy_next        = 1'b1;
                        finished_next    = 1'b0;
                        reply_count_next = '0;
                        min_stamp_next   = MIN_SEED;
                        tally_req.clear  = 1'b1;
                        p_issued_next    = 1'b1;
                        p_kind_next      = REQ_READ;
                        p_req_op_next    = op_inc;
                    end
                end
                else if (fresh)
                begin
                    if (role_reg == ROLE_WRITER)
                    begin
                        if (reached)
                        begin
                            busy_next        = 1'b0;
                            reply_count_next = '0;
                            p_done_next      = 1'b1;
                            p_path_next      = PATH_WRITE;
                            p_res_ts_next    = write_stamp_reg;
                            p_res_val_next   = write_data_reg;
                        end
                        else
                        begin
                            reply_count_next = rc_inc;
                        end
                    end
                    else if (!finished_reg)
                    begin
                        if (kind_reg == RK_RELAY)
                        begin
                            tally_req.start = 1'b1;
                            state_next      = ST_WAIT;
                        end
                        else if (kind_reg == RK_READ_ACK)
                        begin
                            min_stamp_next = min_ts_new;
                            min_data_next  = min_data_new;
                            if (reached)
                            begin
                                finished_next    = 1'b1;
                                busy_next        = 1'b0;
                                reply_count_next = '0;
                                p_done_next      = 1'b1;
                                p_path_next      = PATH_SLOW;
                                p_res_ts_next    = min_ts_new;
                                p_res_val_next   = min_data_new;
                            end
                            else
                            begin
                                reply_count_next = rc_inc;
                            end
                        end
                    end
                end
            end
            ST_WAIT:
            begin
                if (tally_rsp.done)
                begin
                    p_ovf_next = tally_rsp.overflow;
                    if (tally_rsp.complete)
                    begin
                        finished_next    = 1'b1;
                        busy_next        = 1'b0;
                        reply_count_next = '0;
                        p_done_next      = 1'b1;
                        p_path_next      = PATH_FAST;
                        p_res_ts_next    = tally_rsp.stamp;
                        p_res_val_next   = tally_rsp.data;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and client state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            role_reg         <= ROLE_WRITER;
            num_servers_reg  <= 7'd5;
            max_failures_reg <= 6'd1;
            max_ops_reg      <= 32'd100;
            op_counter_reg   <= '0;
            write_stamp_reg  <= '0;
            write_data_reg   <= '0;
            busy_reg         <= 1'b0;
            finished_reg     <= 1'b0;
            reply_count_reg  <= '0;
            min_stamp_reg    <= MIN_SEED;
            min_data_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            op_counter_reg  <= op_counter_next;
            write_stamp_reg <= write_stamp_next;
            write_data_reg  <= write_data_next;
            busy_reg        <= busy_next;
            finished_reg    <= finished_next;
            reply_count_reg <= reply_count_next;
            min_stamp_reg   <= min_stamp_next;
            min_data_reg    <= min_data_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROLE:        role_reg         <= cfg_data[0];
                    CFG_NUM_SERVERS: num_servers_reg  <= cfg_data[6:0];
                    CFG_MAX_FAIL:    max_failures_reg <= cfg_data[5:0];
                    CFG_MAX_OPS:     max_ops_reg      <= cfg_data;
                    default:         role_reg         <= role_reg;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the input word, hold the pending result, drive the output word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg   <= cmd;
            kind_reg  <= reply_kind;
            ts_reg    <= reply_ts;
            value_reg <= reply_value;
            op_reg    <= reply_op;
        end
        p_issued_reg  <= p_issued_next;
        p_kind_reg    <= p_kind_next;
        p_req_ts_reg  <= p_req_ts_next;
        p_req_val_reg <= p_req_val_next;
        p_req_op_reg  <= p_req_op_next;
        p_done_reg    <= p_done_next;
        p_path_reg    <= p_path_next;
        p_res_ts_reg  <= p_res_ts_next;
        p_res_val_reg <= p_res_val_next;
        p_ovf_reg     <= p_ovf_next;
        if (out_load)
        begin
            request_issued <= p_issued_reg;
            request_kind   <= p_kind_reg;
            request_ts     <= p_req_ts_reg;
            request_value  <= p_req_val_reg;
            request_op     <= p_req_op_reg;
            complete       <= p_done_reg;
            complete_path  <= p_path_reg;
            result_ts      <= p_res_ts_reg;
            result_value   <= p_res_val_reg;
            tally_overflow <= p_ovf_reg;
        end
    end

    // Relay tally walker
    qrt_tally #(
        .TALLY_DEPTH (TALLY_DEPTH)
    ) u_tally (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tally_req),
        .rsp   (tally_rsp)
    );

endmodule

[sv/qrt_checker.sv]
// ----------------------------------------------------------------------------
// qrt_checker
// Port-level checks for the quorum reply tally: one word in flight at a time
// and consistent result words.
// ----------------------------------------------------------------------------
module qrt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        request_issued,
    input logic        request_kind,
    input logic [31:0] request_op,
    input logic        complete,
    input logic [1:0]  complete_path,
    input logic [31:0] result_ts
);
    import qrt_pkg::*;

    // Drop ready right after a word is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in flight");

    // A start word never completes an operation
    a_issue_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(request_issued && complete))
        else $error("result word both issues and completes");

    // Idle completion fields read zero
    a_no_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !complete |-> complete_path == PATH_WRITE && result_ts == 32'd0)
        else $error("completion fields set without completion");

    // No request fields without an issued request
    a_no_issue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !request_issued |-> request_kind == REQ_WRITE && request_op == 32'd0)
        else $error("request fields set without a request");

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_ts))
        else $error("stalled result word changed");

endmodule

bind quorum_reply_tally qrt_checker u_qrt_checker (.*);
